// ===== design/jlrt_pkg.sv =====
// package for the journal log reservation table
// opcodes, status codes, controller states and command/status structs
package jlrt_pkg;

   typedef enum logic [2:0] {
      OP_BEGIN  = 3'd0,
      OP_END    = 3'd1,
      OP_WRITE  = 3'd2,
      OP_DONE   = 3'd3,
      OP_QUERY  = 3'd4
   } opcode_type;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_RETRY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_OUTSIDE = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_WAIT,
      S_STREAM,
      S_STREAM_WAIT,
      S_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;      // latch input item
      logic exec;         // run operation on latched item
      logic search_start; // clear scan index
      logic search_step;  // advance scan index
      logic append;       // end of search: append block on a miss, load result
      logic stream_start;
      logic stream_step;
      logic stream_emit;  // load commit entry into result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_write_scan; // latched write that needs a list search
      logic is_stream;     // latched end that starts a commit stream
      logic is_none;       // opcode without result
      logic scan_done;     // scan index at last list entry
      logic scan_hit;
      logic stream_last;
   } stat_type;

endpackage

// ===== design/jlrt_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
module jlrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/jlrt_ctrl.sv =====
// controller state machine of the journal log reservation table
// uses jlrt_pkg
module jlrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  jlrt_pkg::stat_type stat,
   output jlrt_pkg::cmd_type  cmd
);
   import jlrt_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      rsp_load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   // result register free this cycle
   assign rsp_load_ok = !valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff && rsp_stall;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.is_none) begin
               state_in = S_IDLE;
            end else if (stat.is_write_scan) begin
               cmd.search_start = 1'b1;
               state_in = S_SEARCH;
            end else if (stat.is_stream) begin
               cmd.stream_start = 1'b1;
               state_in = S_STREAM;
            end else if (rsp_load_ok) begin
               cmd.exec = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SEARCH: begin
            // ram read issued for current index, compare next cycle
            state_in = S_SEARCH_WAIT;
         end
         S_SEARCH_WAIT: begin
            if (stat.scan_hit || stat.scan_done) begin
               if (rsp_load_ok) begin
                  cmd.append = 1'b1;
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.search_step = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_STREAM: begin
            state_in = S_STREAM_WAIT;
         end
         S_STREAM_WAIT: begin
            if (rsp_load_ok) begin
               cmd.stream_emit = 1'b1;
               valid_in = 1'b1;
               if (stat.stream_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.stream_step = 1'b1;
                  state_in = S_STREAM;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== design/jlrt_dp.sv =====
// datapath of the journal log reservation table: slot table, log list, result register
// uses jlrt_pkg and jlrt_ram
module jlrt_dp #(
   parameter int CLIENT_SLOTS = 8,
   parameter int LOG_ENTRIES  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [5:0]        csr_data,
   input  logic [2:0]        req_opcode,
   input  logic [15:0]       req_client_pid,
   input  logic [5:0]        req_request_min,
   input  logic [5:0]        req_request_ideal,
   input  logic [31:0]       req_block_number,
   input  logic [2:0]        req_query_slot,
   input  jlrt_pkg::cmd_type  cmd,
   output jlrt_pkg::stat_type stat,
   output logic [2:0]        rsp_status,
   output logic [2:0]        rsp_granted_slot,
   output logic [5:0]        rsp_granted_blocks,
   output logic              rsp_absorbed,
   output logic [4:0]        rsp_log_position,
   output logic              rsp_overrun,
   output logic [5:0]        rsp_available_blocks,
   output logic              rsp_commit_entry,
   output logic [31:0]       rsp_commit_block,
   output logic              rsp_last
);
   import jlrt_pkg::*;

   localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int LW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
   localparam int CW = $clog2(LOG_ENTRIES + 1);
   localparam int AW = $clog2(CLIENT_SLOTS + 1);

   logic [5:0]  cap_ff;
   logic [15:0] owner_ff [CLIENT_SLOTS];
   logic [5:0]  resv_ff  [CLIENT_SLOTS];
   logic [5:0]  used_ff  [CLIENT_SLOTS];
   logic [CW-1:0] count_ff;
   logic [AW-1:0] active_ff;
   logic          busy_ff;
   logic [5:0]    retired_ff;

   logic [2:0]  op_ff;
   logic [15:0] pid_ff;
   logic [5:0]  rmin_ff, rideal_ff;
   logic [31:0] blk_ff;
   logic [2:0]  qslot_ff;
   logic [CW-1:0] idx_ff;

   logic [2:0]  o_status_ff;
   logic [2:0]  o_gslot_ff;
   logic [5:0]  o_gblocks_ff;
   logic        o_absorbed_ff;
   logic [4:0]  o_pos_ff;
   logic        o_overrun_ff;
   logic [5:0]  o_avail_ff;
   logic        o_centry_ff;
   logic [31:0] o_cblock_ff;
   logic        o_last_ff;

   // ram
   logic [31:0] rd_data;
   logic        ram_we;
   jlrt_ram #(.WIDTH(32), .DEPTH(LOG_ENTRIES)) u_log (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[LW-1:0]),
      .wr_data(blk_ff),
      .rd_addr(idx_ff[LW-1:0]),
      .rd_data(rd_data)
   );

   // slot lookup
   logic          own_hit, free_hit;
   logic [SW-1:0] own_idx, free_idx;
   logic [9:0]    resv_sum;
   always_comb begin
      own_hit = 1'b0;
      own_idx = '0;
      free_hit = 1'b0;
      free_idx = '0;
      resv_sum = {4'd0, retired_ff};
      for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
         if (pid_ff != 16'd0 && owner_ff[i] == pid_ff) begin
            own_hit = 1'b1;
            own_idx = SW'(i);
         end
         if (owner_ff[i] == 16'd0) begin
            free_hit = 1'b1;
            free_idx = SW'(i);
         end
      end
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
         resv_sum = resv_sum + {4'd0, resv_ff[i]};
      end
   end

   logic [5:0] avail;
   logic [5:0] grant;
   assign avail = ({4'd0, cap_ff} > resv_sum) ? 6'(({4'd0, cap_ff}) - resv_sum) : 6'd0;
   assign grant = (avail < rideal_ff) ? avail : rideal_ff;

   logic [6:0] limit;
   assign limit = ({1'b0, cap_ff} < 7'(LOG_ENTRIES)) ? {1'b0, cap_ff} : 7'(LOG_ENTRIES);
   logic full;
   assign full = 7'(count_ff) >= limit;

   logic [6:0] retired_sum;
   assign retired_sum = {1'b0, retired_ff} + {1'b0, used_ff[own_idx]};

   logic end_ok;
   assign end_ok = own_hit;
   logic [AW-1:0] active_dec;
   assign active_dec = (active_ff != '0) ? active_ff - AW'(1) : active_ff;

   logic [5:0] used_inc;
   assign used_inc = (used_ff[own_idx] < 6'd63) ? used_ff[own_idx] + 6'd1 : used_ff[own_idx];

   logic [5:0] q_r, q_u;
   logic       q_ok;
   assign q_ok = 32'(qslot_ff) < 32'(CLIENT_SLOTS);
   assign q_r  = resv_ff[SW'(qslot_ff)];
   assign q_u  = used_ff[SW'(qslot_ff)];

   assign stat.is_none = op_ff > 3'(OP_QUERY);
   assign stat.is_write_scan = (op_ff == 3'(OP_WRITE)) && !full && active_ff != '0
                               && count_ff != '0;
   assign stat.is_stream = (op_ff == 3'(OP_END)) && end_ok && active_dec == '0
                           && count_ff != '0;
   assign stat.scan_hit = (rd_data == blk_ff);
   assign stat.scan_done = (idx_ff + CW'(1)) >= count_ff;
   assign stat.stream_last = (idx_ff + CW'(1)) >= count_ff;

   // append after a missed search, or straight away into an empty list
   assign ram_we = own_hit && ((cmd.append && !stat.scan_hit)
                               || (cmd.exec && op_ff == 3'(OP_WRITE) && !full
                                   && active_ff != '0));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_opcode;
         pid_ff    <= req_client_pid;
         rmin_ff   <= req_request_min;
         rideal_ff <= req_request_ideal;
         blk_ff    <= req_block_number;
         qslot_ff  <= req_query_slot;
      end
      if (cmd.search_start || cmd.stream_start) begin
         idx_ff <= '0;
      end else if (cmd.search_step || cmd.stream_step) begin
         idx_ff <= idx_ff + CW'(1);
      end
   end

   // state and result
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= 6'd30;
         count_ff   <= '0;
         active_ff  <= '0;
         busy_ff    <= 1'b0;
         retired_ff <= '0;
         for (int i = 0; i < CLIENT_SLOTS; i++) begin
            owner_ff[i] <= '0;
            resv_ff[i]  <= '0;
            used_ff[i]  <= '0;
         end
      end else begin
         if (csr_write) begin
            cap_ff <= csr_data;
         end
         if (cmd.exec) begin
            case (op_ff)
               3'(OP_BEGIN): begin
                  if (pid_ff != 16'd0 && !own_hit && !busy_ff && avail >= rmin_ff
                      && free_hit) begin
                     owner_ff[free_idx] <= pid_ff;
                     resv_ff[free_idx]  <= grant;
                     used_ff[free_idx]  <= '0;
                     active_ff <= active_ff + AW'(1);
                  end
               end
               3'(OP_END): begin
                  if (end_ok) begin
                     retired_ff <= (retired_sum > 7'd63) ? 6'd63 : retired_sum[5:0];
                     owner_ff[own_idx] <= '0;
                     used_ff[own_idx]  <= '0;
                     resv_ff[own_idx]  <= '0;
                     active_ff <= active_dec;
                  end
               end
               3'(OP_DONE): begin
                  if (busy_ff) begin
                     count_ff   <= '0;
                     retired_ff <= '0;
                     busy_ff    <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.stream_start) begin
            retired_ff <= (retired_sum > 7'd63) ? 6'd63 : retired_sum[5:0];
            owner_ff[own_idx] <= '0;
            used_ff[own_idx]  <= '0;
            resv_ff[own_idx]  <= '0;
            active_ff <= active_dec;
            busy_ff   <= 1'b1;
         end
         if (ram_we) begin
            count_ff <= count_ff + CW'(1);
            used_ff[own_idx] <= used_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         o_status_ff   <= ST_OK;
         o_gslot_ff    <= '0;
         o_gblocks_ff  <= '0;
         o_absorbed_ff <= 1'b0;
         o_pos_ff      <= '0;
         o_overrun_ff  <= 1'b0;
         o_avail_ff    <= '0;
         o_centry_ff   <= 1'b0;
         o_cblock_ff   <= '0;
         o_last_ff     <= 1'b1;
         case (op_ff)
            3'(OP_BEGIN): begin
               if (pid_ff == 16'd0 || own_hit) begin
                  o_status_ff <= ST_UNKNOWN;
               end else if (busy_ff || avail < rmin_ff || !free_hit) begin
                  o_status_ff <= ST_RETRY;
               end else begin
                  o_gslot_ff   <= 3'(free_idx);
                  o_gblocks_ff <= grant;
               end
            end
            3'(OP_END): begin
               if (!end_ok) o_status_ff <= ST_UNKNOWN;
            end
            3'(OP_WRITE): begin
               // write without search: empty list, full list or no active client
               if (full) begin
                  o_status_ff <= ST_FULL;
               end else if (active_ff == '0) begin
                  o_status_ff <= ST_OUTSIDE;
               end else if (!own_hit) begin
                  o_status_ff <= ST_UNKNOWN;
               end else begin
                  o_pos_ff     <= 5'(count_ff);
                  o_overrun_ff <= used_inc > resv_ff[own_idx];
               end
            end
            3'(OP_DONE): begin
               if (!busy_ff) o_status_ff <= ST_OUTSIDE;
            end
            3'(OP_QUERY): begin
               if (!q_ok) begin
                  o_status_ff <= ST_UNKNOWN;
               end else begin
                  o_avail_ff <= (q_r > q_u) ? q_r - q_u : 6'd0;
               end
            end
            default: ;
         endcase
      end else if (cmd.append) begin
         o_status_ff   <= ST_OK;
         o_gslot_ff    <= '0;
         o_gblocks_ff  <= '0;
         o_absorbed_ff <= 1'b0;
         o_pos_ff      <= '0;
         o_overrun_ff  <= 1'b0;
         o_avail_ff    <= '0;
         o_centry_ff   <= 1'b0;
         o_cblock_ff   <= '0;
         o_last_ff     <= 1'b1;
         if (stat.scan_hit) begin
            o_absorbed_ff <= 1'b1;
            o_pos_ff      <= 5'(idx_ff);
         end else if (!own_hit) begin
            o_status_ff <= ST_UNKNOWN;
         end else begin
            o_pos_ff     <= 5'(count_ff);
            o_overrun_ff <= used_inc > resv_ff[own_idx];
         end
      end else if (cmd.stream_emit) begin
         o_status_ff   <= ST_OK;
         o_gslot_ff    <= '0;
         o_gblocks_ff  <= '0;
         o_absorbed_ff <= 1'b0;
         o_pos_ff      <= '0;
         o_overrun_ff  <= 1'b0;
         o_avail_ff    <= '0;
         o_centry_ff   <= 1'b1;
         o_cblock_ff   <= rd_data;
         o_last_ff     <= stat.stream_last;
      end
   end

   assign rsp_status           = o_status_ff;
   assign rsp_granted_slot     = o_gslot_ff;
   assign rsp_granted_blocks   = o_gblocks_ff;
   assign rsp_absorbed         = o_absorbed_ff;
   assign rsp_log_position     = o_pos_ff;
   assign rsp_overrun          = o_overrun_ff;
   assign rsp_available_blocks = o_avail_ff;
   assign rsp_commit_entry     = o_centry_ff;
   assign rsp_commit_block     = o_cblock_ff;
   assign rsp_last             = o_last_ff;
endmodule

// ===== design/journal_log_reservation_table.sv =====
// top level of the journal log reservation table
// uses jlrt_pkg, jlrt_ctrl and jlrt_dp
//
// usage: request items enter on req_valid/req_stall with opcode begin, end,
// write, commit done or query; results leave on rsp_valid/rsp_stall, one per
// item except a last end that streams one result per logged block, with
// rsp_last marking the final result of an item. csr_write loads log_capacity;
// the user must use it only while idle; the block does not enforce this.
// One item is taken at a time: S_IDLE captures it, S_RESP loads the result
// register once free; a searching write alternates S_SEARCH and S_SEARCH_WAIT
// per entry as the single ram read port walks the list; a commit stream
// alternates S_STREAM and S_STREAM_WAIT per entry. Opcodes 5 to 7 give no result.
// Reset (synchronous, active high) empties all slots, the list count and
// sets capacity to 30; log ram contents are not cleared.
// When the receiver stalls, the result register holds and the block waits
// before loading the next result.
module journal_log_reservation_table #(
   parameter int CLIENT_SLOTS = 8,
   parameter int LOG_ENTRIES  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [5:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_client_pid,
   input  logic [5:0]  req_request_min,
   input  logic [5:0]  req_request_ideal,
   input  logic [31:0] req_block_number,
   input  logic [2:0]  req_query_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_granted_slot,
   output logic [5:0]  rsp_granted_blocks,
   output logic        rsp_absorbed,
   output logic [4:0]  rsp_log_position,
   output logic        rsp_overrun,
   output logic [5:0]  rsp_available_blocks,
   output logic        rsp_commit_entry,
   output logic [31:0] rsp_commit_block,
   output logic        rsp_last
);
   import jlrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   jlrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   jlrt_dp #(.CLIENT_SLOTS(CLIENT_SLOTS), .LOG_ENTRIES(LOG_ENTRIES)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_data            (csr_data),
      .req_opcode          (req_opcode),
      .req_client_pid      (req_client_pid),
      .req_request_min     (req_request_min),
      .req_request_ideal   (req_request_ideal),
      .req_block_number    (req_block_number),
      .req_query_slot      (req_query_slot),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_status),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_granted_blocks  (rsp_granted_blocks),
      .rsp_absorbed        (rsp_absorbed),
      .rsp_log_position    (rsp_log_position),
      .rsp_overrun         (rsp_overrun),
      .rsp_available_blocks(rsp_available_blocks),
      .rsp_commit_entry    (rsp_commit_entry),
      .rsp_commit_block    (rsp_commit_block),
      .rsp_last            (rsp_last)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.exec, cmd.append, cmd.stream_emit}) <= 1)
      else $error("multiple result loads");
   a_no_load_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(cmd.exec || cmd.append || cmd.stream_emit))
      else $error("result overwritten while stalled");
   a_commit_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_commit_entry) |-> rsp_last)
      else $error("non-commit result without last");
endmodule

// ===== tb/tb_journal_log_reservation_table.sv =====
// testbench for journal_log_reservation_table: directed and random items checked
// against an in-bench predictor of slots, log list and commit stream
// depends on jlrt_pkg and the journal_log_reservation_table rtl
module tb_journal_log_reservation_table;
   timeunit 1ns;
   timeprecision 1ps;
   import jlrt_pkg::*;

   localparam int SLOTS = 8;
   localparam int ENTRIES = 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 80;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] pid;
      logic [5:0]  rmin;
      logic [5:0]  rideal;
      logic [31:0] blk;
      logic [2:0]  qslot;
   } journal_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  gslot;
      logic [5:0]  gblocks;
      logic        absorbed;
      logic [4:0]  pos;
      logic        overrun;
      logic [5:0]  avail;
      logic        centry;
      logic [31:0] cblock;
      logic        last;
   } journal_rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [5:0]  csr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [15:0] req_client_pid = '0;
   logic [5:0]  req_request_min = '0;
   logic [5:0]  req_request_ideal = '0;
   logic [31:0] req_block_number = '0;
   logic [2:0]  req_query_slot = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   journal_rsp_type got;

   // predicted journal state
   logic [5:0]  capacity_m;
   logic [15:0] owner_m[SLOTS];
   int          reserved_m[SLOTS];
   int          used_m[SLOTS];
   logic [31:0] list_m[ENTRIES];
   int          count_m, active_m, retired_m;
   bit          busy_m;
   journal_rsp_type pending_rsp_q[$];

   int  errors = 0, items_sent = 0, rsp_seen = 0, commit_seen = 0, cycles = 0;
   int  hold_cycles = 0;
   bit  calm = 0;

   journal_log_reservation_table i_dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_client_pid(req_client_pid), .req_request_min(req_request_min),
      .req_request_ideal(req_request_ideal), .req_block_number(req_block_number),
      .req_query_slot(req_query_slot), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(got.status), .rsp_granted_slot(got.gslot),
      .rsp_granted_blocks(got.gblocks), .rsp_absorbed(got.absorbed),
      .rsp_log_position(got.pos), .rsp_overrun(got.overrun),
      .rsp_available_blocks(got.avail), .rsp_commit_entry(got.centry),
      .rsp_commit_block(got.cblock), .rsp_last(got.last)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic string rsp_text(journal_rsp_type r);
      return $sformatf(
         "st=%0d slot=%0d grant=%0d abs=%0d pos=%0d ovr=%0d avail=%0d ce=%0d cb=%h last=%0d",
         r.status, r.gslot, r.gblocks, r.absorbed, r.pos, r.overrun, r.avail,
         r.centry, r.cblock, r.last);
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (got.centry) commit_seen++;
         if (pending_rsp_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, got %s", $time, rsp_text(got));
         end else begin
            if (got !== pending_rsp_q[0]) begin
               errors++;
               $display("%0t mismatch: expected %s", $time, rsp_text(pending_rsp_q[0]));
               $display("%0t            actual %s", $time, rsp_text(got));
            end
            void'(pending_rsp_q.pop_front());
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles--;
      end else if (calm) begin
         rsp_stall <= 0;
      end else begin
         rsp_stall <= (r < 25);
         if (r == 0) hold_cycles = $urandom_range(10, 40);
      end
   end

   function automatic int owner_slot(logic [15:0] pid);
      if (pid == 0) return -1;
      for (int i = 0; i < SLOTS; i++)
         if (owner_m[i] == pid) return i;
      return -1;
   endfunction

   task automatic predict_journal(journal_req_type q);
      journal_rsp_type r;
      int s, sum, avail, free, limit, hit;
      r = '0;
      r.last = 1;
      case (q.opcode)
         OP_BEGIN: begin
            if (q.pid == 0 || owner_slot(q.pid) >= 0) r.status = ST_UNKNOWN;
            else if (busy_m) r.status = ST_RETRY;
            else begin
               sum = retired_m;
               free = -1;
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  sum += reserved_m[i];
                  if (owner_m[i] == 0) free = i;
               end
               avail = (capacity_m > sum) ? capacity_m - sum : 0;
               if (avail < q.rmin || free < 0) r.status = ST_RETRY;
               else begin
                  owner_m[free] = q.pid;
                  reserved_m[free] = (avail < q.rideal) ? avail : q.rideal;
                  used_m[free] = 0;
                  active_m++;
                  r.gslot = 3'(free);
                  r.gblocks = 6'(reserved_m[free]);
               end
            end
            pending_rsp_q.push_back(r);
         end
         OP_END: begin
            s = owner_slot(q.pid);
            if (s < 0) begin
               r.status = ST_UNKNOWN;
               pending_rsp_q.push_back(r);
            end else begin
               retired_m = (retired_m + used_m[s] > 63) ? 63 : retired_m + used_m[s];
               owner_m[s] = 0;
               used_m[s] = 0;
               reserved_m[s] = 0;
               if (active_m > 0) active_m--;
               if (active_m == 0 && count_m > 0) begin
                  busy_m = 1;
                  for (int i = 0; i < count_m; i++) begin
                     r.centry = 1;
                     r.cblock = list_m[i];
                     r.last = (i == count_m - 1);
                     pending_rsp_q.push_back(r);
                  end
               end else pending_rsp_q.push_back(r);
            end
         end
         OP_WRITE: begin
            limit = (capacity_m < ENTRIES) ? capacity_m : ENTRIES;
            hit = -1;
            for (int i = count_m - 1; i >= 0; i--)
               if (list_m[i] == q.blk) hit = i;
            s = owner_slot(q.pid);
            if (count_m >= limit) r.status = ST_FULL;
            else if (active_m < 1) r.status = ST_OUTSIDE;
            else if (hit >= 0) begin
               r.absorbed = 1;
               r.pos = 5'(hit);
            end else if (s < 0) r.status = ST_UNKNOWN;
            else begin
               list_m[count_m] = q.blk;
               r.pos = 5'(count_m);
               count_m++;
               if (used_m[s] < 63) used_m[s]++;
               r.overrun = (used_m[s] > reserved_m[s]);
            end
            pending_rsp_q.push_back(r);
         end
         OP_DONE: begin
            if (!busy_m) r.status = ST_OUTSIDE;
            else begin
               count_m = 0;
               retired_m = 0;
               busy_m = 0;
            end
            pending_rsp_q.push_back(r);
         end
         OP_QUERY: begin
            if (q.qslot >= SLOTS) r.status = ST_UNKNOWN;
            else if (reserved_m[q.qslot] > used_m[q.qslot])
               r.avail = 6'(reserved_m[q.qslot] - used_m[q.qslot]);
            pending_rsp_q.push_back(r);
         end
         default: ;
      endcase
   endtask

   function automatic journal_req_type mk(logic [2:0] op, logic [15:0] pid, logic [5:0] rmin,
                                          logic [5:0] rideal, logic [31:0] blk,
                                          logic [2:0] qslot);
      journal_req_type q;
      q = '{op, pid, rmin, rideal, blk, qslot};
      return q;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(journal_req_type q, bit gaps = 1);
      int gap;
      req_valid <= 1;
      req_opcode <= q.opcode;
      req_client_pid <= q.pid;
      req_request_min <= q.rmin;
      req_request_ideal <= q.rideal;
      req_block_number <= q.blk;
      req_query_slot <= q.qslot;
      do @(posedge clock); while (req_stall);
      predict_journal(q);
      if (q.opcode <= OP_QUERY) items_sent++;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_capacity(logic [5:0] value);
      drain();
      csr_write <= 1;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      capacity_m = value;
   endtask

   task automatic test_directed();
      send_item(mk(OP_BEGIN, 16'h0000, 0, 5, 0, 0));
      send_item(mk(OP_BEGIN, 16'hFFFF, 0, 63, 0, 0));
      send_item(mk(OP_BEGIN, 16'hFFFF, 0, 1, 0, 0));
      send_item(mk(OP_BEGIN, 16'h0002, 1, 1, 0, 0));
      send_item(mk(OP_QUERY, 16'h0000, 0, 0, 0, 0));
      send_item(mk(OP_WRITE, 16'hFFFF, 0, 0, 32'h0000_0000, 0));
      send_item(mk(OP_WRITE, 16'hFFFF, 0, 0, 32'hFFFF_FFFF, 0));
      send_item(mk(OP_WRITE, 16'hFFFF, 0, 0, 32'h0000_0000, 0));
      send_item(mk(OP_WRITE, 16'h0007, 0, 0, 32'h0000_0005, 0));
      send_item(mk(OP_WRITE, 16'h0007, 0, 0, 32'hFFFF_FFFF, 0));
      send_item(mk(OP_QUERY, 16'h0000, 0, 0, 0, 7));
      send_item(mk(OP_END, 16'h0003, 0, 0, 0, 0));
      send_item(mk(OP_END, 16'h0000, 0, 0, 0, 0));
      send_item(mk(OP_END, 16'hFFFF, 0, 0, 0, 0));
      send_item(mk(OP_BEGIN, 16'h0002, 0, 3, 0, 0));
      send_item(mk(OP_WRITE, 16'h0002, 0, 0, 32'h1234_5678, 0));
      send_item(mk(OP_DONE, 16'h0000, 0, 0, 0, 0));
      send_item(mk(OP_DONE, 16'h0000, 0, 0, 0, 0));
      send_item(mk(3'd5, 16'h0002, 0, 0, 0, 0));
      send_item(mk(3'd6, 16'h0002, 0, 0, 0, 0));
      send_item(mk(3'd7, 16'h0002, 0, 0, 0, 0));
      send_item(mk(OP_BEGIN, 16'h0002, 0, 0, 0, 0));
      send_item(mk(OP_WRITE, 16'h0002, 0, 0, 32'hA5A5_5A5A, 0));
      send_item(mk(OP_END, 16'h0002, 0, 0, 0, 0));
      send_item(mk(OP_DONE, 16'h0000, 0, 0, 0, 0));
   endtask

   task automatic test_capacity_extremes();
      set_capacity(6'd1);
      send_item(mk(OP_BEGIN, 16'h0004, 0, 5, 0, 0));
      send_item(mk(OP_WRITE, 16'h0004, 0, 0, 32'd10, 0));
      send_item(mk(OP_WRITE, 16'h0004, 0, 0, 32'd11, 0));
      send_item(mk(OP_END, 16'h0004, 0, 0, 0, 0));
      send_item(mk(OP_DONE, 16'h0000, 0, 0, 0, 0));
      set_capacity(6'd32);
      for (int i = 0; i < SLOTS + 1; i++)
         send_item(mk(OP_BEGIN, 16'(100 + i), 0, 1, 0, 0));
      send_item(mk(OP_BEGIN, 16'd200, 63, 63, 0, 0));
      for (int i = 0; i < SLOTS; i++)
         send_item(mk(OP_END, 16'(100 + i), 0, 0, 0, 0));
   endtask

   task automatic test_backpressure();
      drain();
      hold_cycles = 200;
      for (int i = 0; i < 12; i++)
         send_item(mk(OP_QUERY, 16'h0000, 0, 0, 0, i[2:0]), 0);
      drain();
   endtask

   function automatic logic [15:0] live_pid();
      int s;
      s = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < SLOTS; i++)
         if (owner_m[(s + i) % SLOTS] != 0) return owner_m[(s + i) % SLOTS];
      return 16'($urandom_range(1, 12));
   endfunction

   task automatic test_random(int n);
      journal_req_type q;
      int r, k;
      k = 0;
      while (k < n) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         q.opcode = 3'($urandom);
         q.pid = 16'($urandom);
         q.rmin = 6'($urandom);
         q.rideal = 6'($urandom);
         q.blk = $urandom;
         q.qslot = 3'($urandom);
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 9) != 0) q.pid = 16'($urandom_range(1, 12));
         if (r < 22) begin
            q.opcode = OP_BEGIN;
            if ($urandom_range(0, 7) != 0) begin
               q.rmin = 6'($urandom_range(0, 6));
               q.rideal = 6'($urandom_range(0, 12));
            end
         end else if (r < 60) begin
            q.opcode = OP_WRITE;
            if ($urandom_range(0, 4) != 0) q.pid = live_pid();
            if ($urandom_range(0, 4) < 3) q.blk = $urandom_range(0, 40);
         end else if (r < 75) begin
            q.opcode = OP_END;
            if ($urandom_range(0, 4) != 0) q.pid = live_pid();
         end else if (r < 85) q.opcode = OP_DONE;
         else if (r < 95) q.opcode = OP_QUERY;
         else if (r < 98) q.opcode = 3'($urandom_range(5, 7));
         else begin
            q.opcode = OP_BEGIN;
            q.pid = '0;
         end
         send_item(q);
         if (q.opcode <= OP_QUERY) k++;
      end
      calm = 0;
   endtask

   initial begin
      capacity_m = 6'd30;
      for (int i = 0; i < SLOTS; i++) begin
         owner_m[i] = 0;
         reserved_m[i] = 0;
         used_m[i] = 0;
      end
      count_m = 0;
      active_m = 0;
      retired_m = 0;
      busy_m = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_capacity_extremes();
      test_backpressure();
      set_capacity(6'd20);
      test_random(95);
      set_capacity(6'd32);
      test_random(95);
      set_capacity(6'd5);
      test_random(70);
      set_capacity(6'd30);
      test_random(95);
      drain();
      $display("covered %0d items (begin/end/write/done/query), %0d results, %0d commit entries",
               items_sent, rsp_seen, commit_seen);
      $display("capacities 1 to 32, slot exhaustion, absorption, overrun and long receiver stall");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
